// File: rtl/bfpv_pkg.sv
// shared types, constants and the cordic arctangent table for the body-frame
// velocity controller; no dependencies
package bfpv_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int MAX_STAGES    = 24;
   localparam int POS_WIDTH     = 16;
   localparam int STAGE_W       = $clog2(MAX_STAGES);
   localparam int NUM_STAGES    = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;

   localparam int DIFF_W  = POS_WIDTH + 1;   // position error
   localparam int ANG_W   = 16;
   localparam int GAIN_W  = 16;
   localparam int OUT_W   = 24;
   localparam int CORD_W  = 32;               // q2.30 datapath

   localparam logic signed [CORD_W-1:0] X_INIT = 32'sh26DD3B6A;

   // gains, q4.12: about 0.2 and 0.8
   localparam logic [GAIN_W-1:0] LINEAR_GAIN_RST  = 16'd819;
   localparam logic [GAIN_W-1:0] ANGULAR_GAIN_RST = 16'd3277;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_LINEAR_GAIN  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGULAR_GAIN = 1'd1;

   typedef struct packed {
      logic signed [ANG_W-1:0] actual_x;
      logic signed [ANG_W-1:0] actual_y;
      logic signed [ANG_W-1:0] actual_yaw;
      logic signed [ANG_W-1:0] target_x;
      logic signed [ANG_W-1:0] target_y;
      logic signed [ANG_W-1:0] target_yaw;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] fwd_cmd;
      logic signed [OUT_W-1:0] side_cmd;
      logic signed [OUT_W-1:0] turn_cmd;
   } rsp_type;

   typedef struct packed {
      logic signed [CORD_W-1:0] x;
      logic signed [CORD_W-1:0] y;
      logic signed [CORD_W-1:0] z;
   } cordic_type;

   // data riding along the rotation chain
   typedef struct packed {
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
      logic signed [ANG_W-1:0]  yaw_err;
      logic                     flip;
   } side_type;

   // atan(2^-i), 2^32 per turn, truncated
   function automatic logic signed [CORD_W-1:0] atan_entry(input logic [STAGE_W-1:0] idx);
      logic signed [CORD_W-1:0] v;
      case (idx)
         5'd0:    v = 32'sh20000000;
         5'd1:    v = 32'sh12E4051D;
         5'd2:    v = 32'sh09FB385B;
         5'd3:    v = 32'sh051111D4;
         5'd4:    v = 32'sh028B0D43;
         5'd5:    v = 32'sh0145D7E1;
         5'd6:    v = 32'sh00A2F61E;
         5'd7:    v = 32'sh00517C55;
         5'd8:    v = 32'sh0028BE53;
         5'd9:    v = 32'sh00145F2E;
         5'd10:   v = 32'sh000A2F98;
         5'd11:   v = 32'sh000517CC;
         5'd12:   v = 32'sh00028BE6;
         5'd13:   v = 32'sh000145F3;
         5'd14:   v = 32'sh0000A2F9;
         5'd15:   v = 32'sh0000517C;
         5'd16:   v = 32'sh000028BE;
         5'd17:   v = 32'sh0000145F;
         5'd18:   v = 32'sh00000A2F;
         5'd19:   v = 32'sh00000517;
         5'd20:   v = 32'sh0000028B;
         5'd21:   v = 32'sh00000145;
         5'd22:   v = 32'sh000000A2;
         5'd23:   v = 32'sh00000051;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// File: rtl/body_frame_p_velocity_controller_core.sv
// body-frame proportional pose controller: input register, cordic cell chain,
// then rounding, rotation, gain and saturation stages; depends on bfpv_pkg and
// bfpv_cordic_cell

// Takes one actual/target pose pair per cycle unless the output is stalled,
// and returns one velocity command transaction per pose pair, in order. Each
// pair passes one input register, one cordic cell per stage, then cos/sin
// rounding, rotation products, sums, gain products and the output register.
// Every stage holds one transaction and loads whenever it is empty or its
// content moves on, so throughput is one transaction per cycle unless the
// output is stalled, and empty slots close up while it is. Gains written
// through the csr port apply to transactions that reach the gain stages afterwards.
module body_frame_p_velocity_controller_core import bfpv_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [GAIN_W-1:0]    csr_wdata
);

   localparam int CS_W  = 18;                 // rounded cos / sin
   localparam int PRD_W = DIFF_W + CS_W;
   localparam int ROT_W = PRD_W + 1;
   localparam int LG_W  = ROT_W + GAIN_W + 1;
   localparam int AG_W  = ANG_W + GAIN_W + 1;
   localparam int SAT_W = 64;

   localparam logic signed [LG_W-1:0]   LIN_RND = LG_W'(1) <<< 26;
   localparam logic signed [AG_W-1:0]   ANG_RND = AG_W'(1) <<< 11;
   localparam logic signed [CORD_W:0]   CS_RND  = (CORD_W + 1)'(1) <<< 14;
   localparam logic signed [SAT_W-1:0]  OUT_MAX = (SAT_W'(1) <<< (OUT_W - 1)) - SAT_W'(1);
   localparam logic signed [SAT_W-1:0]  OUT_MIN = -(SAT_W'(1) <<< (OUT_W - 1));

   function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SAT_W-1:0] v);
      logic signed [OUT_W-1:0] r;
      if (v > OUT_MAX) begin
         r = OUT_MAX[OUT_W-1:0];
      end else if (v < OUT_MIN) begin
         r = OUT_MIN[OUT_W-1:0];
      end else begin
         r = v[OUT_W-1:0];
      end
      return r;
   endfunction

   // ---------------- gain registers
   logic [GAIN_W-1:0] lin_gain_ff, ang_gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lin_gain_ff <= LINEAR_GAIN_RST;
         ang_gain_ff <= ANGULAR_GAIN_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LINEAR_GAIN:  lin_gain_ff <= csr_wdata;
            CSR_ANGULAR_GAIN: ang_gain_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- stage enables, closing up empty slots
   logic en_s0, en_k1, en_k2, en_k3, en_k4, en_out;
   logic s0_valid_ff, k1_valid_ff, k2_valid_ff, k3_valid_ff, k4_valid_ff, rsp_valid_ff;

   logic       chain_valid [0:NUM_STAGES];
   cordic_type chain_cord  [0:NUM_STAGES];
   side_type   chain_side  [0:NUM_STAGES];
   logic       chain_take  [0:NUM_STAGES];

   assign en_out = !rsp_valid_ff || !rsp_stall;
   assign en_k4  = !k4_valid_ff || en_out;
   assign en_k3  = !k3_valid_ff || en_k4;
   assign en_k2  = !k2_valid_ff || en_k3;
   assign en_k1  = !k1_valid_ff || en_k2;
   assign chain_take[NUM_STAGES] = en_k1;
   assign en_s0  = !s0_valid_ff || chain_take[0];

   assign req_stall = !en_s0;

   // ---------------- input stage: errors and heading reduction
   logic signed [POS_WIDTH-1:0] ax, ay, tx, ty;
   logic signed [ANG_W-1:0]     yaw;
   logic                        flip;
   logic [ANG_W-1:0]            yaw_red;
   side_type                    s0_side_ff, s0_side_in;
   cordic_type                  s0_cord_ff, s0_cord_in;

   always_comb begin
      ax  = $signed(req_data.actual_x[POS_WIDTH-1:0]);
      ay  = $signed(req_data.actual_y[POS_WIDTH-1:0]);
      tx  = $signed(req_data.target_x[POS_WIDTH-1:0]);
      ty  = $signed(req_data.target_y[POS_WIDTH-1:0]);
      yaw = req_data.actual_yaw;
      // beyond a quarter turn: rotate by half a turn, negate cos and sin later
      flip = (yaw > 16'sd16384) || (yaw < -16'sd16384);
      yaw_red = flip ? {~yaw[ANG_W-1], yaw[ANG_W-2:0]} : yaw;
      s0_side_in.dx      = {tx[POS_WIDTH-1], tx} - {ax[POS_WIDTH-1], ax};
      s0_side_in.dy      = {ty[POS_WIDTH-1], ty} - {ay[POS_WIDTH-1], ay};
      s0_side_in.yaw_err = req_data.target_yaw - req_data.actual_yaw;
      s0_side_in.flip    = flip;
      s0_cord_in.x = X_INIT;
      s0_cord_in.y = '0;
      s0_cord_in.z = $signed({yaw_red, {(CORD_W - ANG_W){1'b0}}});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en_s0) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en_s0) begin
         s0_side_ff <= s0_side_in;
         s0_cord_ff <= s0_cord_in;
      end
   end

   assign chain_valid[0] = s0_valid_ff;
   assign chain_cord[0]  = s0_cord_ff;
   assign chain_side[0]  = s0_side_ff;

   // ---------------- cordic cell chain
   for (genvar i = 0; i < NUM_STAGES; i++) begin : g_cell
      bfpv_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_idx (STAGE_W'(i)),
         .in_valid  (chain_valid[i]),
         .in_cord   (chain_cord[i]),
         .in_side   (chain_side[i]),
         .take      (chain_take[i]),
         .next_take (chain_take[i+1]),
         .out_valid (chain_valid[i+1]),
         .out_cord  (chain_cord[i+1]),
         .out_side  (chain_side[i+1])
      );
   end

   // ---------------- k1: round cos / sin to q1.15, undo the half-turn
   logic signed [CORD_W:0]   x_rnd, y_rnd;
   logic signed [CS_W-1:0]   c_raw, s_raw;
   logic signed [CS_W-1:0]   k1_c_ff, k1_s_ff, k1_c_in, k1_s_in;
   side_type                 k1_side_ff;

   always_comb begin
      x_rnd = {chain_cord[NUM_STAGES].x[CORD_W-1], chain_cord[NUM_STAGES].x} + CS_RND;
      y_rnd = {chain_cord[NUM_STAGES].y[CORD_W-1], chain_cord[NUM_STAGES].y} + CS_RND;
      c_raw = $signed(x_rnd[CORD_W:15]);
      s_raw = $signed(y_rnd[CORD_W:15]);
      k1_c_in = chain_side[NUM_STAGES].flip ? -c_raw : c_raw;
      k1_s_in = chain_side[NUM_STAGES].flip ? -s_raw : s_raw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k1_valid_ff <= 1'b0;
      end else if (en_k1) begin
         k1_valid_ff <= chain_valid[NUM_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (en_k1) begin
         k1_c_ff    <= k1_c_in;
         k1_s_ff    <= k1_s_in;
         k1_side_ff <= chain_side[NUM_STAGES];
      end
   end

   // ---------------- k2: rotation products and heading error times gain
   logic signed [PRD_W-1:0] k2_dxc_ff, k2_dys_ff, k2_dyc_ff, k2_dxs_ff;
   logic signed [AG_W-1:0]  k2_ang_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         k2_valid_ff <= 1'b0;
      end else if (en_k2) begin
         k2_valid_ff <= k1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_k2) begin
         k2_dxc_ff <= PRD_W'(k1_side_ff.dx) * PRD_W'(k1_c_ff);
         k2_dys_ff <= PRD_W'(k1_side_ff.dy) * PRD_W'(k1_s_ff);
         k2_dyc_ff <= PRD_W'(k1_side_ff.dy) * PRD_W'(k1_c_ff);
         k2_dxs_ff <= PRD_W'(k1_side_ff.dx) * PRD_W'(k1_s_ff);
         k2_ang_ff <= AG_W'(k1_side_ff.yaw_err) * AG_W'($signed({1'b0, ang_gain_ff}));
      end
   end

   // ---------------- k3: body-frame error
   logic signed [ROT_W-1:0] k3_tan_ff, k3_nor_ff;
   logic signed [AG_W-1:0]  k3_ang_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         k3_valid_ff <= 1'b0;
      end else if (en_k3) begin
         k3_valid_ff <= k2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_k3) begin
         k3_tan_ff <= ROT_W'(k2_dxc_ff) + ROT_W'(k2_dys_ff);
         k3_nor_ff <= ROT_W'(k2_dyc_ff) - ROT_W'(k2_dxs_ff);
         k3_ang_ff <= k2_ang_ff;
      end
   end

   // ---------------- k4: linear gain
   logic signed [LG_W-1:0] k4_tan_ff, k4_nor_ff;
   logic signed [AG_W-1:0] k4_ang_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         k4_valid_ff <= 1'b0;
      end else if (en_k4) begin
         k4_valid_ff <= k3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_k4) begin
         k4_tan_ff <= LG_W'(k3_tan_ff) * LG_W'($signed({1'b0, lin_gain_ff}));
         k4_nor_ff <= LG_W'(k3_nor_ff) * LG_W'($signed({1'b0, lin_gain_ff}));
         k4_ang_ff <= k3_ang_ff;
      end
   end

   // ---------------- output register: round and saturate
   logic signed [LG_W-1:0] tan_sh, nor_sh;
   logic signed [AG_W-1:0] ang_sh;
   rsp_type                rsp_ff, rsp_in;

   always_comb begin
      tan_sh = (k4_tan_ff + LIN_RND) >>> 27;
      nor_sh = (k4_nor_ff + LIN_RND) >>> 27;
      ang_sh = (k4_ang_ff + ANG_RND) >>> 12;
      rsp_in.fwd_cmd  = sat_out(SAT_W'(tan_sh));
      rsp_in.side_cmd = sat_out(SAT_W'(nor_sh));
      rsp_in.turn_cmd = sat_out(SAT_W'(ang_sh));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en_out) begin
         rsp_valid_ff <= k4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------- checks
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> s0_valid_ff)
      else $error("accepted transaction did not reach the input stage");

   a_empty_head_takes: assert property (@(posedge clock) disable iff (reset)
      !s0_valid_ff |-> !req_stall)
      else $error("input stalled while the input stage is empty");

   a_cos_range: assert property (@(posedge clock) disable iff (reset)
      k1_valid_ff |-> (k1_c_ff <= 18'sd32770) && (k1_c_ff >= -18'sd32770)
                      && (k1_s_ff <= 18'sd32770) && (k1_s_ff >= -18'sd32770))
      else $error("rounded cos or sin out of range");

   a_out_fills: assert property (@(posedge clock) disable iff (reset)
      k4_valid_ff && !rsp_valid_ff |=> rsp_valid_ff)
      else $error("empty output register did not take a finished transaction");

endmodule

// File: rtl/bfpv_cordic_cell.sv
// one rotation-mode cordic cell of the heading chain, with its own valid and
// load enable; depends on bfpv_pkg
module bfpv_cordic_cell import bfpv_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [STAGE_W-1:0] stage_idx,
   input  logic               in_valid,
   input  cordic_type         in_cord,
   input  side_type           in_side,
   output logic               take,
   input  logic               next_take,
   output logic               out_valid,
   output cordic_type         out_cord,
   output side_type           out_side
);

   logic       valid_ff;
   cordic_type cord_ff, cord_in;
   side_type   side_ff;

   logic signed [CORD_W-1:0] xs, ys, ang;

   // a cell loads when empty or when its content moves on
   assign take = !valid_ff || next_take;

   always_comb begin
      xs  = in_cord.x >>> stage_idx;
      ys  = in_cord.y >>> stage_idx;
      ang = atan_entry(stage_idx);
      if (!in_cord.z[CORD_W-1]) begin
         cord_in.x = in_cord.x - ys;
         cord_in.y = in_cord.y + xs;
         cord_in.z = in_cord.z - ang;
      end else begin
         cord_in.x = in_cord.x + ys;
         cord_in.y = in_cord.y - xs;
         cord_in.z = in_cord.z + ang;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cord_ff <= cord_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_cord  = cord_ff;
   assign out_side  = side_ff;

endmodule

// File: bench/body_frame_p_velocity_controller_core_tb.sv
// testbench for body_frame_p_velocity_controller_core: directed and random pose pairs
// under several gain settings and idle patterns, each velocity command checked in order
// against a predictor in this file; depends on bfpv_pkg and the core rtl
module body_frame_p_velocity_controller_core_tb;
   import bfpv_pkg::*;

   localparam int IDLE_LIMIT       = 5000;
   localparam int TAIL_CYCLES      = NUM_STAGES + 16;
   localparam int RANDOM_PER_PHASE = 225;
   localparam int NUM_PHASES       = 6;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_stall;
   rsp_type              rsp_data;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [GAIN_W-1:0]    csr_wdata;

   req_type           pending_poses[$];
   rsp_type           expected_cmds[$];
   logic [GAIN_W-1:0] lin_gain_now = LINEAR_GAIN_RST;
   logic [GAIN_W-1:0] ang_gain_now = ANGULAR_GAIN_RST;
   int                send_idle_pct = 0;
   int                rsp_stall_pct = 0;
   int                poses_queued = 0;
   int                poses_taken = 0;
   int                mismatch_count = 0;
   int                quiet_cycles = 0;
   logic              req_taken = 1'b0;

   // atan(2^-i) with 2^32 per turn, truncated
   longint rot_angle [24] = '{
      64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
      64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2E, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C, 64'h000028BE, 64'h0000145F,
      64'h00000A2F, 64'h00000517, 64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051
   };

   body_frame_p_velocity_controller_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic signed [OUT_W-1:0] clamp_command(input longint v);
      if (v > 64'sd8388607) return 24'sh7FFFFF;
      if (v < -64'sd8388608) return 24'sh800000;
      return v[OUT_W-1:0];
   endfunction

   function automatic logic signed [OUT_W-1:0] scale_position(input longint rot,
                                                              input longint gain);
      longint mag;
      mag = (rot < 0) ? -rot : rot;
      if (gain == 0) return '0;
      // product would leave 63 bits: saturate toward the sign
      if (mag > (64'sd1 <<< 62) / gain) return (rot < 0) ? 24'sh800000 : 24'sh7FFFFF;
      return clamp_command((rot * gain + (64'sd1 <<< 26)) >>> 27);
   endfunction

   function automatic rsp_type predict_command(input req_type pose,
                                                input logic [GAIN_W-1:0] lin,
                                                input logic [GAIN_W-1:0] ang);
      longint dx, dy, cx, cy, cz, xs, ys, cs, sn, lin_g, ang_g, yaw_e;
      logic signed [ANG_W-1:0] head;
      logic signed [ANG_W-1:0] yaw_diff;
      logic flip;
      int i;
      rsp_type cmd;
      dx = pose.target_x;
      dx = dx - pose.actual_x;
      dy = pose.target_y;
      dy = dy - pose.actual_y;
      // headings past a quarter turn go through the cordic half a turn away
      flip = (pose.actual_yaw > 16384) || (pose.actual_yaw < -16384);
      head = flip ? (pose.actual_yaw ^ 16'h8000) : pose.actual_yaw;
      cx = 64'sh26DD3B6A;
      cy = 0;
      cz = head;
      cz = cz * 65536;
      for (i = 0; i < NUM_STAGES; i++) begin
         xs = cx >>> i;
         ys = cy >>> i;
         if (cz >= 0) begin
            cx = cx - ys;
            cy = cy + xs;
            cz = cz - rot_angle[i];
         end else begin
            cx = cx + ys;
            cy = cy - xs;
            cz = cz + rot_angle[i];
         end
      end
      cs = (cx + 16384) >>> 15;
      sn = (cy + 16384) >>> 15;
      if (flip) begin
         cs = -cs;
         sn = -sn;
      end
      lin_g = lin;
      ang_g = ang;
      cmd.fwd_cmd  = scale_position(dx * cs + dy * sn, lin_g);
      cmd.side_cmd = scale_position(dy * cs - dx * sn, lin_g);
      yaw_diff = pose.target_yaw - pose.actual_yaw;
      yaw_e = yaw_diff;
      cmd.turn_cmd = clamp_command((yaw_e * ang_g + 2048) >>> 12);
      return cmd;
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic queue_pose(input int ax, input int ay, input int ayaw,
                             input int tx, input int ty, input int tyaw);
      req_type pose;
      pose.actual_x   = 16'(ax);
      pose.actual_y   = 16'(ay);
      pose.actual_yaw = 16'(ayaw);
      pose.target_x   = 16'(tx);
      pose.target_y   = 16'(ty);
      pose.target_yaw = 16'(tyaw);
      pending_poses.push_back(pose);
      poses_queued++;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_poses.size() != 0 || poses_taken != poses_queued ||
             expected_cmds.size() != 0);
   endtask

   task automatic write_gain(input logic [CSR_IDX_W-1:0] idx, input logic [GAIN_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_LINEAR_GAIN) lin_gain_now = value;
      else ang_gain_now = value;
   endtask

   // driver: new transaction only once the current one is taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         if (!req_valid || req_taken) begin
            if (pending_poses.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= pending_poses.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // monitor, checker and watchdog
   always @(posedge clock) begin
      rsp_type want;
      logic    rsp_taken;
      req_taken = !reset && req_valid && !req_stall;
      rsp_taken = !reset && rsp_valid && !rsp_stall;
      if (req_taken) begin
         expected_cmds.push_back(predict_command(req_data, lin_gain_now, ang_gain_now));
         poses_taken++;
      end
      if (rsp_taken) begin
         if (expected_cmds.size() == 0) begin
            report_mismatch("command transaction with none expected");
         end else begin
            want = expected_cmds.pop_front();
            if (rsp_data.fwd_cmd !== want.fwd_cmd)
               report_mismatch($sformatf("fwd_cmd got %0d want %0d",
                                         rsp_data.fwd_cmd, want.fwd_cmd));
            if (rsp_data.side_cmd !== want.side_cmd)
               report_mismatch($sformatf("side_cmd got %0d want %0d",
                                         rsp_data.side_cmd, want.side_cmd));
            if (rsp_data.turn_cmd !== want.turn_cmd)
               report_mismatch($sformatf("turn_cmd got %0d want %0d",
                                         rsp_data.turn_cmd, want.turn_cmd));
         end
      end
      if (req_taken || rsp_taken) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("body_frame_p_velocity_controller_core test failed");
         $finish;
      end
   end

   initial begin
      int p, k, ax, ay, ayaw, tx, ty, tyaw;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_stall = 1'b0;
      csr_we    = 1'b0;
      csr_index = CSR_LINEAR_GAIN;
      csr_wdata = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // position extremes, quarter and half turn boundaries, yaw error wrap
      queue_pose(0, 0, 0, 0, 0, 0);
      queue_pose(-32768, -32768, 0, 32767, 32767, 0);
      queue_pose(32767, 32767, 0, -32768, -32768, 0);
      queue_pose(-32768, 32767, 16384, 32767, -32768, -16384);
      queue_pose(100, -200, -16384, -300, 400, 16384);
      queue_pose(1000, 2000, 16385, -1000, -2000, -16385);
      queue_pose(1000, 2000, -16385, -1000, -2000, 16385);
      queue_pose(-5, 7, 32767, 5, -7, -32768);
      queue_pose(-5, 7, -32768, 5, -7, 32767);
      queue_pose(0, 0, -32768, 0, 0, 0);
      queue_pose(12345, -23456, 8192, -30000, 30000, -8192);
      queue_pose(32767, -32768, -8192, -32768, 32767, 24576);
      queue_pose(300, 300, 24576, 300, 300, 24576);
      queue_pose(-1, -1, -1, -1, -1, -1);
      queue_pose(0, 0, 16383, 32767, 0, 16383);
      queue_pose(0, 0, -16383, 0, 32767, -16383);
      queue_pose(-32768, -32768, -32768, 32767, 32767, 32767);
      queue_pose(32767, 32767, 32767, -32768, -32768, -32768);

      for (p = 0; p < NUM_PHASES; p++) begin
         case (p)
            1: begin
               write_gain(CSR_LINEAR_GAIN, 16'hFFFF);
               write_gain(CSR_ANGULAR_GAIN, 16'hFFFF);
            end
            2: begin
               write_gain(CSR_LINEAR_GAIN, 16'h0000);
               write_gain(CSR_ANGULAR_GAIN, 16'h0000);
            end
            4: begin
               write_gain(CSR_LINEAR_GAIN, 16'h1000);
               write_gain(CSR_ANGULAR_GAIN, 16'h0001);
            end
            3, 5: begin
               write_gain(CSR_LINEAR_GAIN, 16'($urandom));
               write_gain(CSR_ANGULAR_GAIN, 16'($urandom));
            end
            default: ;
         endcase
         case (p % 4)
            1: begin
               send_idle_pct = 58;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 58;
            end
            3: begin
               send_idle_pct = 12;
               rsp_stall_pct = 12;
            end
            default: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
         endcase
         for (k = 0; k < RANDOM_PER_PHASE; k++) begin
            // sender holds off mid phase until the pipeline is empty
            if (k == RANDOM_PER_PHASE / 2) wait_drained();
            ax   = $urandom;
            ay   = $urandom;
            ayaw = $urandom;
            tx   = $urandom;
            ty   = $urandom;
            tyaw = $urandom;
            if ($urandom_range(99) < 25) begin
               // target close to the actual pose
               tx   = ax + ($urandom_range(0, 400) - 200);
               ty   = ay + ($urandom_range(0, 400) - 200);
               tyaw = ayaw + ($urandom_range(0, 2000) - 1000);
            end
            if ($urandom_range(99) < 15) begin
               case ($urandom_range(0, 3))
                  0:       ayaw = 16384;
                  1:       ayaw = -16384;
                  2:       ayaw = 32767;
                  default: ayaw = 0;
               endcase
               ayaw = ayaw + ($urandom_range(0, 6) - 3);
            end
            queue_pose(ax, ay, ayaw, tx, ty, tyaw);
         end
         wait_drained();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("body_frame_p_velocity_controller_core test passed");
      end else begin
         $display("body_frame_p_velocity_controller_core test failed");
      end
      $finish;
   end

endmodule
